FILE: rtl/core/tsch_pkg.sv
// ----------------------------------------------------------------------------
// Thread scheduler package
// Shared widths, request and priority codes and the structs that pass
// between the scheduler core and its ready queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsch_pkg;

  localparam int TID_W       = 6;
  localparam int NUM_THREADS = 1 << TID_W;
  localparam int CNT_W       = TID_W + 1;
  localparam int PRIO_W      = 2;
  localparam int NUM_QUEUES  = 3;
  localparam int REQ_W       = 3;

  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [PRIO_W-1:0] prio_t;
  typedef logic [TID_W-1:0]  tid_t;

  localparam req_t REQ_CREATE = 3'd0;
  localparam req_t REQ_YIELD  = 3'd1;
  localparam req_t REQ_PYIELD = 3'd2;
  localparam req_t REQ_FINISH = 3'd3;
  localparam req_t REQ_SETPRI = 3'd4;
  localparam req_t REQ_JOIN   = 3'd5;

  localparam prio_t PRIO_HIGH = 2'd0;
  localparam prio_t PRIO_MED  = 2'd1;
  localparam prio_t PRIO_LOW  = 2'd2;
  localparam prio_t PRIO_BAD  = 2'd3;

  typedef struct packed {
    logic  en;
    tid_t  tid;
    prio_t prio;
  } enq_t;

  typedef struct packed {
    logic [NUM_QUEUES-1:0] nonempty;
    prio_t                 top;
  } rq_stat_t;

  typedef struct packed {
    tid_t  tid;
    prio_t prio;
  } waiter_t;

endpackage

`default_nettype wire

FILE: rtl/core/tsch_if.sv
// ----------------------------------------------------------------------------
// Scheduler channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tsch_req_if import tsch_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [1:0]  priority_in;
  logic [5:0]  target_tid;

  modport source (output valid, req_type, priority_in, target_tid, input ready);
  modport sink (input valid, req_type, priority_in, target_tid, output ready);
endinterface

interface tsch_res_if import tsch_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        status;
  logic        running_valid;
  logic [5:0]  running_tid;
  logic [5:0]  created_tid;

  modport source (output valid, status, running_valid, running_tid, created_tid,
                  input ready);
  modport sink (input valid, status, running_valid, running_tid, created_tid,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tsch_rq.sv
// ----------------------------------------------------------------------------
// Ready queues
// Three circular FIFOs of thread ids in one memory, with one enqueue and
// one dequeue port; the dequeue always takes the highest non-empty queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsch_rq import tsch_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire enq_t enq,
  input  wire logic deq,
  output rq_stat_t  stat,
  output tid_t      deq_tid
);

  localparam int ADDR_W = PRIO_W + TID_W;
  localparam int DEPTH  = NUM_QUEUES * NUM_THREADS;

  tid_t             store [0:DEPTH-1];
  tid_t             head  [0:NUM_QUEUES-1];
  tid_t             tail  [0:NUM_QUEUES-1];
  logic [CNT_W-1:0] count [0:NUM_QUEUES-1];
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      stat.nonempty[q] = (count[q] != '0);
    end
    if (stat.nonempty[0]) begin
      stat.top = PRIO_HIGH;
    end else if (stat.nonempty[1]) begin
      stat.top = PRIO_MED;
    end else begin
      stat.top = PRIO_LOW;
    end
    wr_addr = {enq.prio, tail[enq.prio]};
    rd_addr = {stat.top, head[stat.top]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head[q]  <= '0;
        tail[q]  <= '0;
        count[q] <= '0;
      end
    end else begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        if (enq.en && enq.prio == prio_t'(q)) begin
          tail[q] <= tail[q] + 1'b1;
        end
        if (deq && stat.top == prio_t'(q)) begin
          head[q] <= head[q] + 1'b1;
        end
        count[q] <= count[q]
                    + CNT_W'(enq.en && enq.prio == prio_t'(q))
                    - CNT_W'(deq && stat.top == prio_t'(q));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq.en) begin
      store[wr_addr] <= enq.tid;
    end
    if (deq) begin
      deq_tid <= store[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/three_level_priority_thread_scheduler_core.sv
// A request that starts no dispatch goes from the execute state straight to
// the done state, which gives its result beat. A dispatch adds the dispatch
// state, and the dispatch read state when a queue is non-empty, and a finish
// adds the finish state before them. One request is in work at a time: a new
// one is taken only when the sequencer is back in idle. Reset is synchronous:
// thread 0 runs at low priority, all queues and join entries are empty.
// ----------------------------------------------------------------------------
// Three-level priority thread scheduler
// Strict-priority dispatch from three FIFO ready queues, with a join table
// that holds one blocked waiter per target thread.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module three_level_priority_thread_scheduler_core import tsch_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  tsch_req_if.sink  req,
  tsch_res_if.source res
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_FIN  = 6'b000100,
    S_DISP = 6'b001000,
    S_DRD  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t             state;
  req_t               req_r;
  prio_t              prio_r;
  tid_t               target_r;
  logic [CNT_W-1:0]   next_id;
  tid_t               cur_tid;
  logic               cur_valid;
  prio_t              cur_prio;
  logic [NUM_THREADS-1:0] blocked;
  logic [NUM_THREADS-1:0] join_valid;
  waiter_t            jtab [0:NUM_THREADS-1];
  waiter_t            jtab_rd;
  logic               jv_r;
  logic               err;
  logic               empty_err;
  tid_t               created;
  logic               res_valid;
  logic               res_status;
  logic               res_run_valid;
  tid_t               res_run_tid;
  tid_t               res_created;

  enq_t               enq;
  logic               deq;
  rq_stat_t           stat;
  tid_t               deq_tid;
  logic               create_ok;
  logic               pyield_go;

  tsch_rq u_rq (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .deq     (deq),
    .stat    (stat),
    .deq_tid (deq_tid)
  );

  assign req.ready         = (state == S_IDLE);
  assign res.valid         = res_valid;
  assign res.status        = res_status;
  assign res.running_valid = res_run_valid;
  assign res.running_tid   = res_run_tid;
  assign res.created_tid   = res_created;

  always_comb begin
    create_ok = (next_id < CNT_W'(NUM_THREADS)) && (prio_r != PRIO_BAD);
    pyield_go = (cur_prio == PRIO_MED && stat.nonempty[0]) ||
                (cur_prio == PRIO_LOW && (stat.nonempty[0] || stat.nonempty[1]));
    enq = '0;
    deq = 1'b0;
    case (state)
      S_EXEC: begin
        case (req_r)
          REQ_CREATE: begin
            if (create_ok) begin
              enq = '{en: 1'b1, tid: next_id[TID_W-1:0], prio: prio_r};
            end
          end
          REQ_YIELD: begin
            if (cur_valid) begin
              enq = '{en: 1'b1, tid: cur_tid, prio: cur_prio};
            end
          end
          REQ_PYIELD: begin
            if (cur_valid && pyield_go) begin
              enq = '{en: 1'b1, tid: cur_tid, prio: cur_prio};
            end
          end
          default: begin
          end
        endcase
      end
      S_FIN: begin
        if (jv_r && blocked[jtab_rd.tid]) begin
          enq = '{en: 1'b1, tid: jtab_rd.tid, prio: jtab_rd.prio};
        end
      end
      S_DISP: begin
        deq = |stat.nonempty;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && req_r == REQ_FINISH) begin
      jtab_rd <= jtab[cur_tid];
    end
    if (state == S_EXEC && req_r == REQ_JOIN && cur_valid && !join_valid[target_r]) begin
      jtab[target_r] <= '{tid: cur_tid, prio: cur_prio};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_id    <= CNT_W'(1);
      cur_tid    <= '0;
      cur_valid  <= 1'b1;
      cur_prio   <= PRIO_LOW;
      blocked    <= '0;
      join_valid <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && res.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_r     <= req.req_type;
            prio_r    <= req.priority_in;
            target_r  <= req.target_tid;
            err       <= 1'b0;
            empty_err <= 1'b0;
            created   <= '0;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          case (req_r)
            REQ_CREATE: begin
              if (create_ok) begin
                next_id <= next_id + 1'b1;
                created <= next_id[TID_W-1:0];
              end else begin
                err <= 1'b1;
              end
            end
            REQ_YIELD: begin
              empty_err <= !cur_valid;
              state     <= S_DISP;
            end
            REQ_PYIELD: begin
              if (!cur_valid) begin
                err <= 1'b1;
              end else if (pyield_go) begin
                state <= S_DISP;
              end
            end
            REQ_FINISH: begin
              if (!cur_valid) begin
                err <= 1'b1;
              end else begin
                jv_r  <= join_valid[cur_tid];
                state <= S_FIN;
              end
            end
            REQ_SETPRI: begin
              if (!cur_valid || prio_r == PRIO_BAD) begin
                err <= 1'b1;
              end else begin
                cur_prio <= prio_r;
              end
            end
            REQ_JOIN: begin
              if (!cur_valid || join_valid[target_r]) begin
                err <= 1'b1;
              end else begin
                join_valid[target_r] <= 1'b1;
                blocked[cur_tid]     <= 1'b1;
                state                <= S_DISP;
              end
            end
            default: begin
              err <= 1'b1;
            end
          endcase
        end
        S_FIN: begin
          if (enq.en) begin
            blocked[jtab_rd.tid] <= 1'b0;
          end
          state <= S_DISP;
        end
        S_DISP: begin
          if (deq) begin
            cur_prio <= stat.top;
            state    <= S_DRD;
          end else begin
            cur_valid <= 1'b0;
            cur_tid   <= '0;
            if (empty_err) begin
              err <= 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_DRD: begin
          cur_tid   <= deq_tid;
          cur_valid <= 1'b1;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || res.ready) begin
            res_valid     <= 1'b1;
            res_status    <= err;
            res_run_valid <= cur_valid;
            res_run_tid   <= cur_valid ? cur_tid : '0;
            res_created   <= created;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_drd_runs: assert property (@(posedge clk) disable iff (rst)
    state == S_DRD |=> cur_valid)
    else $error("dispatch read did not leave a running thread");

  a_id_bound: assert property (@(posedge clk) disable iff (rst)
    next_id <= CNT_W'(NUM_THREADS))
    else $error("thread id counter ran past the thread count");

  a_created_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_created != '0 |-> !res_status)
    else $error("created id reported with an error status");

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!res_valid || res.ready) |=> res_valid && state == S_IDLE)
    else $error("finished request did not produce a result beat");

endmodule

`default_nettype wire
